### design/kfi_pkg.sv
// Shared types, codes and constants of the keyframe interpolator.
package kfi_pkg;

  localparam int MaxFrames  = 16;
  localparam int ValueWidth = 32;
  localparam int NumValues  = 9;
  localparam int RatioFrac  = 16;
  localparam int DivSteps   = 32 + RatioFrac;

  localparam logic [31:0] RatioMax = 32'h4000_0000;
  localparam logic [31:0] BezOne   = 32'h0001_0000;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_CONST  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_BEZIER = 2'd2,
    MODE_HOLD   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_MODE        = 3'd0,
    CFG_REPEAT      = 3'd1,
    CFG_UPD_POS     = 3'd2,
    CFG_UPD_ANG     = 3'd3,
    CFG_UPD_SCL     = 3'd4,
    CFG_FRAME_COUNT = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_DEC,
    ST_DIV,
    ST_COMP,
    ST_C_RD,
    ST_C_WR,
    ST_L_RA,
    ST_L_RB,
    ST_L_ST,
    ST_L_WT,
    ST_B_RD,
    ST_B_WR,
    ST_B_L0,
    ST_B_L1,
    ST_B_ST,
    ST_B_WT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         frame_index;
    logic [1:0]         attribute;
    logic [31:0]        frame_time;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [31:0]        elapsed;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] ang_x;
    logic signed [31:0] ang_y;
    logic signed [31:0] ang_z;
    logic signed [31:0] scl_x;
    logic signed [31:0] scl_y;
    logic signed [31:0] scl_z;
    logic               applied;
    logic               finished;
  } out_t;

endpackage

### design/kfi_div.sv
// Bit-serial signed divider producing the Q.16 interpolation ratio.
module kfi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               bez_i,
  input  logic signed [32:0] num_i,
  input  logic signed [32:0] den_i,
  output logic               done_o,
  output logic signed [31:0] ratio_o
);

  localparam int QW = 32 + kfi_pkg::RatioFrac;
  localparam int CW = $clog2(kfi_pkg::DivSteps);

  logic [QW-1:0]  dq_q;
  logic [31:0]    rem_q;
  logic [31:0]    den_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, fin_q, done_q;
  logic           neg_q, zero_q, bez_q;
  logic [31:0]    ratio_q;

  logic [32:0]    num_mag, den_mag, rsh, rdif;
  logic           ge;
  logic [31:0]    qm_lin, qm_bez, res_w;

  assign num_mag = num_i[32] ? 33'(-num_i) : 33'(num_i);
  assign den_mag = den_i[32] ? 33'(-den_i) : 33'(den_i);
  assign rsh     = {rem_q, dq_q[QW-1]};
  assign ge      = rsh >= {1'b0, den_q};
  assign rdif    = rsh - {1'b0, den_q};

  assign qm_lin = (dq_q > QW'(kfi_pkg::RatioMax)) ? kfi_pkg::RatioMax : dq_q[31:0];
  assign qm_bez = (dq_q > QW'(kfi_pkg::BezOne)) ? kfi_pkg::BezOne : dq_q[31:0];

  always_comb begin
    if (zero_q) begin
      res_w = '0;
    end else if (bez_q) begin
      res_w = neg_q ? '0 : qm_bez;
    end else begin
      res_w = neg_q ? 32'(-qm_lin) : qm_lin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(kfi_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q   <= {num_mag[31:0], {kfi_pkg::RatioFrac{1'b0}}};
      rem_q  <= '0;
      den_q  <= den_mag[31:0];
      neg_q  <= num_i[32] ^ den_i[32];
      zero_q <= (den_i == '0);
      bez_q  <= bez_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[QW-2:0], ge};
      rem_q <= ge ? rdif[31:0] : rsh[31:0];
    end
    if (fin_q) begin
      ratio_q <= res_w;
    end
  end

  assign done_o  = done_q;
  assign ratio_o = $signed(ratio_q);

endmodule

### design/kfi_lerp.sv
// Shared lerp unit: a + floor((b - a) * ratio / 2^16), saturated, one multiplier.
module kfi_lerp #(
  parameter int VALUE_WIDTH = kfi_pkg::ValueWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [VALUE_WIDTH-1:0] a_i,
  input  logic signed [VALUE_WIDTH-1:0] b_i,
  input  logic signed [31:0]            ratio_i,
  output logic                          done_o,
  output logic signed [VALUE_WIDTH-1:0] y_o
);

  localparam int DW = VALUE_WIDTH + 1;
  localparam int MW = 17;
  localparam int PW = DW + MW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] Hi =
    $signed({{(SW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] Lo = ~Hi;

  logic signed [VALUE_WIDTH-1:0] a_q, y_q;
  logic signed [DW-1:0]          diff_q;
  logic signed [PW-1:0]          phi_q, plo_q, prod;
  logic signed [MW-1:0]          mop;
  logic signed [SW-1:0]          sum;
  logic [1:0]                    ph_q;
  logic                          busy_q, done_q;

  // The ratio is split into a signed high half and an unsigned low half.
  assign mop  = (ph_q == 2'd0) ? MW'(ratio_i >>> kfi_pkg::RatioFrac)
                               : $signed({1'b0, ratio_i[15:0]});
  assign prod = diff_q * mop;
  assign sum  = SW'(a_q) + SW'(phi_q) + SW'(plo_q >>> kfi_pkg::RatioFrac);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (busy_q) begin
        ph_q <= ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      diff_q <= DW'(b_i) - DW'(a_i);
    end else if (busy_q) begin
      case (ph_q)
        2'd0: phi_q <= prod;
        2'd1: plo_q <= prod;
        default: begin
          if (sum > Hi) begin
            y_q <= Hi[VALUE_WIDTH-1:0];
          end else if (sum < Lo) begin
            y_q <= Lo[VALUE_WIDTH-1:0];
          end else begin
            y_q <= sum[VALUE_WIDTH-1:0];
          end
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

### design/keyframe_interpolator_core.sv
// Top level of the keyframe interpolator: sequencer, keyframe memories and result register.
//
//   Channel  | Direction | Handshake                 | Payload
//   ---------+-----------+---------------------------+--------------------------
//   in       | input     | in_valid_i / in_stall_o   | in_data_i  (kfi_pkg::in_t)
//   out      | output    | out_valid_o / out_stall_i | out_data_o (kfi_pkg::out_t)
//   cfg      | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// The time a tick takes depends on the mode and on the number of enabled values, and in
// Bezier mode also on the number of frames; the 48-step divider and the one shared
// multiplier of the lerp unit set it.
// Reset is asynchronous and active low; the keyframe stores are not cleared and must
// be loaded before use. A stalled result is held in the output register; a following
// tick waits for it, loads and clears proceed.
module keyframe_interpolator_core #(
  parameter int MAX_FRAMES  = kfi_pkg::MaxFrames,
  parameter int VALUE_WIDTH = kfi_pkg::ValueWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  kfi_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output kfi_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [4:0]    cfg_data_i
);

  localparam int FIW = $clog2(MAX_FRAMES);
  localparam int NW  = $clog2(MAX_FRAMES + 1);
  localparam int KD  = MAX_FRAMES * kfi_pkg::NumValues;
  localparam int KAW = $clog2(KD);

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  // Configuration registers.
  kfi_pkg::mode_e mode_q;
  logic           rep_q;
  logic [2:0]     upd_q;
  logic [4:0]     fc_q;

  // Sequencer and animation state.
  kfi_pkg::state_e state_q, state_d;
  kfi_pkg::in_t    in_q;
  logic [31:0]     ct_q, t0_q, tg_q, tl_q;
  logic [FIW-1:0]  cf_q, fb_q, k_q;
  logic [NW-1:0]   lvl_q;
  logic            done_q, applied_q;
  logic [3:0]      idx_q;
  logic [1:0]      ld_cnt_q;
  logic signed [31:0] rt_q;
  val_t            av_q, prev_q, bv_q;
  val_t            res_q [kfi_pkg::NumValues];
  kfi_pkg::out_t   out_q;
  logic            out_valid_q;

  // Memories.
  logic [31:0] kt_mem [MAX_FRAMES];
  logic [31:0] kt_rd_q;
  val_t        kv_mem [KD];
  val_t        kv_rd_q;
  val_t        scr_mem [MAX_FRAMES];
  val_t        scr_rd_q;

  logic [FIW-1:0] kt_raddr, scr_raddr, scr_waddr;
  logic [KAW-1:0] kv_raddr, kv_waddr;
  logic           kt_we, kv_we, scr_we;
  val_t           kv_wdata, scr_wdata;

  // Shared units.
  logic               div_start, div_done;
  logic signed [32:0] div_num, div_den;
  logic signed [31:0] div_ratio;
  logic               lerp_start, lerp_done;
  val_t               lerp_a, lerp_b, lerp_y;

  // Decode helpers.
  logic [NW-1:0]  n_w;
  logic [NW:0]    f1;
  logic           fg_ok, past_g, past_l, before0, restart_b, lin_end, enabled;
  logic [FIW-1:0] cf_adv;
  logic [31:0]    ct_eff;
  logic [32:0]    ct_sum;
  logic [31:0]    ct_sat;
  logic           accept, load_ok, more_k, more_lvl, last_copy, out_free;
  logic [1:0]     attr_w;

  function automatic logic [KAW-1:0] kv_addr(input logic [FIW-1:0] slot,
                                              input logic [3:0] off);
    kv_addr = KAW'(slot) * KAW'(kfi_pkg::NumValues) + KAW'(off);
  endfunction

  always_comb begin
    if (fc_q == '0) begin
      n_w = NW'(1);
    end else if (32'(fc_q) > 32'(MAX_FRAMES)) begin
      n_w = NW'(MAX_FRAMES);
    end else begin
      n_w = NW'(fc_q);
    end
  end

  assign f1        = (NW+1)'(cf_q) + 1'b1;
  assign fg_ok     = f1 < (NW+1)'(n_w);
  assign past_g    = ct_q > tg_q;
  assign past_l    = ct_q > tl_q;
  assign before0   = ct_q < t0_q;
  assign cf_adv    = (past_g && mode_q != kfi_pkg::MODE_BEZIER) ? cf_q + 1'b1 : cf_q;
  assign lin_end   = (NW+1)'(cf_adv) + 1'b1 >= (NW+1)'(n_w);
  assign restart_b = (mode_q == kfi_pkg::MODE_BEZIER) && past_g && past_l;
  assign ct_eff    = (restart_b && rep_q) ? '0 : ct_q;
  assign ct_sum    = {1'b0, ct_q} + {1'b0, in_data_i.elapsed};
  assign ct_sat    = ct_sum[32] ? '1 : ct_sum[31:0];

  assign accept   = in_valid_i && !in_stall_o;
  assign load_ok  = (32'(in_data_i.frame_index) < 32'(MAX_FRAMES)) &&
                    (in_data_i.attribute != 2'd3);
  assign attr_w   = (idx_q < 4'd3) ? 2'd0 : ((idx_q < 4'd6) ? 2'd1 : 2'd2);
  assign enabled  = upd_q[attr_w];
  assign more_k   = (NW+2)'(k_q) + (NW+2)'(lvl_q) + 1'b1 < (NW+2)'(n_w);
  assign more_lvl = (NW+1)'(lvl_q) + 1'b1 < (NW+1)'(n_w);
  assign last_copy = (NW+1)'(k_q) + 1'b1 == (NW+1)'(n_w);
  assign out_free = !out_valid_q || !out_stall_i;

  // Linear divides the time into the segment; Bezier divides it by the whole span.
  always_comb begin
    if (mode_q == kfi_pkg::MODE_BEZIER) begin
      div_num = $signed({1'b0, ct_eff});
      div_den = $signed({1'b0, tl_q} - {1'b0, t0_q});
    end else begin
      div_num = $signed({1'b0, ct_q} - {1'b0, kt_rd_q});
      div_den = $signed({1'b0, tg_q} - {1'b0, kt_rd_q});
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kfi_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data_i.kind)
            kfi_pkg::KIND_TICK: state_d = done_q ? kfi_pkg::ST_OUT : kfi_pkg::ST_T0;
            kfi_pkg::KIND_LOAD: state_d = load_ok ? kfi_pkg::ST_LOAD : kfi_pkg::ST_IDLE;
            default:            state_d = kfi_pkg::ST_IDLE;
          endcase
        end
      end
      kfi_pkg::ST_LOAD: if (ld_cnt_q == 2'd2) state_d = kfi_pkg::ST_IDLE;
      kfi_pkg::ST_T0:   state_d = kfi_pkg::ST_T1;
      kfi_pkg::ST_T1:   state_d = kfi_pkg::ST_T2;
      kfi_pkg::ST_T2:   state_d = kfi_pkg::ST_T3;
      kfi_pkg::ST_T3:   state_d = kfi_pkg::ST_DEC;
      kfi_pkg::ST_DEC: begin
        if (before0 || !fg_ok) begin
          state_d = kfi_pkg::ST_OUT;
        end else begin
          unique case (mode_q)
            kfi_pkg::MODE_CONST:  state_d = kfi_pkg::ST_COMP;
            kfi_pkg::MODE_LINEAR: state_d = lin_end ? kfi_pkg::ST_OUT : kfi_pkg::ST_DIV;
            kfi_pkg::MODE_BEZIER: state_d = kfi_pkg::ST_DIV;
            default:              state_d = kfi_pkg::ST_OUT;
          endcase
        end
      end
      kfi_pkg::ST_DIV: if (div_done) state_d = kfi_pkg::ST_COMP;
      kfi_pkg::ST_COMP: begin
        if (idx_q == 4'(kfi_pkg::NumValues)) begin
          state_d = kfi_pkg::ST_OUT;
        end else if (enabled) begin
          unique case (mode_q)
            kfi_pkg::MODE_CONST:  state_d = kfi_pkg::ST_C_RD;
            kfi_pkg::MODE_LINEAR: state_d = kfi_pkg::ST_L_RA;
            default:              state_d = kfi_pkg::ST_B_RD;
          endcase
        end
      end
      kfi_pkg::ST_C_RD: state_d = kfi_pkg::ST_C_WR;
      kfi_pkg::ST_C_WR: state_d = kfi_pkg::ST_COMP;
      kfi_pkg::ST_L_RA: state_d = kfi_pkg::ST_L_RB;
      kfi_pkg::ST_L_RB: state_d = kfi_pkg::ST_L_ST;
      kfi_pkg::ST_L_ST: state_d = kfi_pkg::ST_L_WT;
      kfi_pkg::ST_L_WT: if (lerp_done) state_d = kfi_pkg::ST_COMP;
      kfi_pkg::ST_B_RD: state_d = kfi_pkg::ST_B_WR;
      kfi_pkg::ST_B_WR: state_d = last_copy ? kfi_pkg::ST_B_L0 : kfi_pkg::ST_B_RD;
      kfi_pkg::ST_B_L0: state_d = kfi_pkg::ST_B_L1;
      kfi_pkg::ST_B_L1: state_d = kfi_pkg::ST_B_ST;
      kfi_pkg::ST_B_ST: state_d = kfi_pkg::ST_B_WT;
      kfi_pkg::ST_B_WT: begin
        if (lerp_done) begin
          if (more_k) begin
            state_d = kfi_pkg::ST_B_ST;
          end else if (more_lvl) begin
            state_d = kfi_pkg::ST_B_L0;
          end else begin
            state_d = kfi_pkg::ST_COMP;
          end
        end
      end
      kfi_pkg::ST_OUT: if (out_free) state_d = kfi_pkg::ST_IDLE;
      default: state_d = kfi_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: memory addresses, write strobes and unit starts.
  always_comb begin
    kt_raddr   = '0;
    kv_raddr   = kv_addr(fb_q, idx_q);
    scr_raddr  = '0;
    kt_we      = 1'b0;
    kv_we      = 1'b0;
    kv_waddr   = kv_addr(FIW'(in_q.frame_index),
                         4'(in_q.attribute) * 4'd3 + 4'(ld_cnt_q));
    scr_we     = 1'b0;
    scr_waddr  = k_q;
    scr_wdata  = kv_rd_q;
    div_start  = 1'b0;
    lerp_start = 1'b0;
    lerp_a     = av_q;
    lerp_b     = kv_rd_q;
    case (ld_cnt_q)
      2'd0:    kv_wdata = VALUE_WIDTH'(in_q.vec_x);
      2'd1:    kv_wdata = VALUE_WIDTH'(in_q.vec_y);
      default: kv_wdata = VALUE_WIDTH'(in_q.vec_z);
    endcase
    unique case (state_q)
      kfi_pkg::ST_LOAD: begin
        kv_we = 1'b1;
        kt_we = (ld_cnt_q == 2'd0);
      end
      kfi_pkg::ST_T0: kt_raddr = '0;
      kfi_pkg::ST_T1: kt_raddr = FIW'(f1);
      kfi_pkg::ST_T2: kt_raddr = FIW'(n_w - 1'b1);
      kfi_pkg::ST_T3: kt_raddr = cf_q;
      kfi_pkg::ST_DEC: begin
        div_start = !before0 && fg_ok &&
                    ((mode_q == kfi_pkg::MODE_LINEAR && !lin_end) ||
                     mode_q == kfi_pkg::MODE_BEZIER);
      end
      kfi_pkg::ST_L_RB: kv_raddr = kv_addr(fb_q + 1'b1, idx_q);
      kfi_pkg::ST_L_ST: lerp_start = 1'b1;
      kfi_pkg::ST_B_RD: kv_raddr = kv_addr(k_q, idx_q);
      kfi_pkg::ST_B_WR: scr_we = 1'b1;
      kfi_pkg::ST_B_L0: scr_raddr = '0;
      kfi_pkg::ST_B_L1: scr_raddr = k_q + 1'b1;
      kfi_pkg::ST_B_ST: begin
        lerp_start = 1'b1;
        lerp_a     = prev_q;
        lerp_b     = scr_rd_q;
      end
      kfi_pkg::ST_B_WT: begin
        scr_raddr = k_q + 2'd2;
        scr_we    = lerp_done;
        scr_wdata = lerp_y;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    kt_rd_q  <= kt_mem[kt_raddr];
    kv_rd_q  <= kv_mem[kv_raddr];
    scr_rd_q <= scr_mem[scr_raddr];
    if (kt_we) kt_mem[FIW'(in_q.frame_index)] <= in_q.frame_time;
    if (kv_we) kv_mem[kv_waddr] <= kv_wdata;
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
  end

  kfi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .bez_i   (mode_q == kfi_pkg::MODE_BEZIER),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .ratio_o (div_ratio)
  );

  kfi_lerp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_lerp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lerp_start),
    .a_i     (lerp_a),
    .b_i     (lerp_b),
    .ratio_i (rt_q),
    .done_o  (lerp_done),
    .y_o     (lerp_y)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= kfi_pkg::MODE_CONST;
      rep_q  <= 1'b0;
      upd_q  <= 3'b111;
      fc_q   <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kfi_pkg::CFG_MODE:        mode_q   <= kfi_pkg::mode_e'(cfg_data_i[1:0]);
        kfi_pkg::CFG_REPEAT:      rep_q    <= cfg_data_i[0];
        kfi_pkg::CFG_UPD_POS:     upd_q[0] <= cfg_data_i[0];
        kfi_pkg::CFG_UPD_ANG:     upd_q[1] <= cfg_data_i[0];
        kfi_pkg::CFG_UPD_SCL:     upd_q[2] <= cfg_data_i[0];
        kfi_pkg::CFG_FRAME_COUNT: fc_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kfi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Animation state, counters and results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ct_q        <= '0;
      cf_q        <= '0;
      done_q      <= 1'b0;
      applied_q   <= 1'b0;
      idx_q       <= '0;
      ld_cnt_q    <= '0;
      k_q         <= '0;
      lvl_q       <= '0;
      fb_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < kfi_pkg::NumValues; i++) res_q[i] <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        kfi_pkg::ST_IDLE: begin
          if (accept) begin
            ld_cnt_q  <= '0;
            applied_q <= 1'b0;
            case (in_data_i.kind)
              kfi_pkg::KIND_TICK:  if (!done_q) ct_q <= ct_sat;
              kfi_pkg::KIND_CLEAR: done_q <= 1'b0;
              default: ;
            endcase
          end
        end
        kfi_pkg::ST_LOAD: ld_cnt_q <= ld_cnt_q + 1'b1;
        kfi_pkg::ST_DEC: begin
          fb_q  <= cf_q;
          idx_q <= '0;
          if (!before0) begin
            if (fg_ok) begin
              cf_q <= cf_adv;
              if (restart_b) begin
                if (rep_q) begin
                  ct_q <= '0;
                  cf_q <= '0;
                end else begin
                  done_q <= 1'b1;
                end
              end
              unique case (mode_q)
                kfi_pkg::MODE_CONST:  applied_q <= 1'b1;
                kfi_pkg::MODE_LINEAR: applied_q <= !lin_end;
                kfi_pkg::MODE_BEZIER: applied_q <= 1'b1;
                default:              applied_q <= 1'b0;
              endcase
            end else if (rep_q) begin
              ct_q <= '0;
              cf_q <= '0;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        kfi_pkg::ST_COMP: begin
          k_q <= '0;
          if (idx_q != 4'(kfi_pkg::NumValues) && !enabled) idx_q <= idx_q + 1'b1;
        end
        kfi_pkg::ST_C_WR: begin
          res_q[idx_q] <= kv_rd_q;
          idx_q        <= idx_q + 1'b1;
        end
        kfi_pkg::ST_L_WT: begin
          if (lerp_done) begin
            res_q[idx_q] <= lerp_y;
            idx_q        <= idx_q + 1'b1;
          end
        end
        kfi_pkg::ST_B_WR: begin
          if (last_copy) begin
            k_q   <= '0;
            lvl_q <= NW'(1);
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        kfi_pkg::ST_B_WT: begin
          if (lerp_done) begin
            if (more_k) begin
              k_q <= k_q + 1'b1;
            end else if (more_lvl) begin
              k_q   <= '0;
              lvl_q <= lvl_q + 1'b1;
            end else begin
              res_q[idx_q] <= lerp_y;
              idx_q        <= idx_q + 1'b1;
            end
          end
        end
        kfi_pkg::ST_OUT: if (out_free) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (state_q == kfi_pkg::ST_DIV && div_done) rt_q <= div_ratio;
    if (state_q == kfi_pkg::ST_T1) t0_q <= kt_rd_q;
    if (state_q == kfi_pkg::ST_T2) tg_q <= kt_rd_q;
    if (state_q == kfi_pkg::ST_T3) tl_q <= kt_rd_q;
    if (state_q == kfi_pkg::ST_L_RB) av_q <= kv_rd_q;
    if (state_q == kfi_pkg::ST_B_L1) prev_q <= scr_rd_q;
    if (state_q == kfi_pkg::ST_B_ST) bv_q <= scr_rd_q;
    if (state_q == kfi_pkg::ST_B_WT && lerp_done) prev_q <= bv_q;
    if (state_q == kfi_pkg::ST_OUT && out_free) begin
      out_q.pos_x    <= 32'(res_q[0]);
      out_q.pos_y    <= 32'(res_q[1]);
      out_q.pos_z    <= 32'(res_q[2]);
      out_q.ang_x    <= 32'(res_q[3]);
      out_q.ang_y    <= 32'(res_q[4]);
      out_q.ang_z    <= 32'(res_q[5]);
      out_q.scl_x    <= 32'(res_q[6]);
      out_q.scl_y    <= 32'(res_q[7]);
      out_q.scl_z    <= 32'(res_q[8]);
      out_q.applied  <= applied_q;
      out_q.finished <= done_q;
    end
  end

  assign in_stall_o  = (state_q != kfi_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/tb.sv
// Self-checking testbench for the keyframe interpolator core.
module tb;
  import kfi_pkg::*;

  // Attribute codes of a load transaction; the last one is not a valid vector.
  localparam logic [1:0] AttrPos = 2'd0;
  localparam logic [1:0] AttrAng = 2'd1;
  localparam logic [1:0] AttrScl = 2'd2;
  localparam logic [1:0] AttrBad = 2'd3;
  // Transaction kind that the block must ignore.
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int RandomItems = 450;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_t        in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [4:0] cfg_data_i = '0;

  keyframe_interpolator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the animation state, kept in step with accepted transactions.
  logic [31:0] key_time[MaxFrames];
  longint      key_val[MaxFrames * NumValues];
  longint      held_val[NumValues];
  logic [31:0] anim_clock;
  int          cur_frame;
  bit          anim_done;
  mode_e       cur_mode;
  bit          repeat_on;
  bit          upd_en[3];
  int          frame_cnt;

  out_t        frame_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          burst_left = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // One blend step: a + floor((b - a) * r / 2^16). The arithmetic shift floors.
  function automatic longint blend(longint a, longint b, longint r);
    return a + (((b - a) * r) >>> 16);
  endfunction

  function automatic void restart_or_finish();
    if (repeat_on) begin
      anim_clock = '0;
      cur_frame = 0;
    end else begin
      anim_done = 1'b1;
    end
  endfunction

  function automatic void hold_frame(int f);
    for (int i = 0; i < NumValues; i++)
      if (upd_en[i / 3]) held_val[i] = key_val[f * NumValues + i];
  endfunction

  function automatic void lerp_frames(int f, int g);
    longint num, den, r;
    num = longint'(anim_clock) - longint'(key_time[f]);
    den = longint'(key_time[g]) - longint'(key_time[f]);
    r = (den == 0) ? 0 : (num * 65536) / den;
    if (r > (64'sd1 <<< 30)) r = 64'sd1 <<< 30;
    if (r < -(64'sd1 <<< 30)) r = -(64'sd1 <<< 30);
    for (int i = 0; i < NumValues; i++)
      if (upd_en[i / 3])
        held_val[i] = sat32(blend(key_val[f * NumValues + i], key_val[g * NumValues + i], r));
  endfunction

  function automatic void casteljau(int n);
    longint span, t;
    longint pts[MaxFrames];
    span = longint'(key_time[n - 1]) - longint'(key_time[0]);
    t = (span == 0) ? 0 : (longint'(anim_clock) * 65536) / span;
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    for (int i = 0; i < NumValues; i++) begin
      if (!upd_en[i / 3]) continue;
      for (int k = 0; k < n; k++) pts[k] = key_val[k * NumValues + i];
      for (int lvl = 1; lvl < n; lvl++)
        for (int k = 0; k + lvl < n; k++) pts[k] = blend(pts[k], pts[k + 1], t);
      held_val[i] = sat32(pts[0]);
    end
  endfunction

  // Advances the shadow clock by one tick and returns whether new values were applied.
  function automatic bit advance_tick(logic [31:0] elapsed);
    int n, f, g;
    n = (frame_cnt == 0) ? 1 : ((frame_cnt > MaxFrames) ? MaxFrames : frame_cnt);
    if (anim_done) return 1'b0;
    anim_clock = (anim_clock > ~elapsed) ? 32'hFFFF_FFFF : anim_clock + elapsed;
    if (anim_clock < key_time[0]) return 1'b0;
    f = cur_frame;
    if (f + 1 < n) begin
      g = f + 1;
      if (anim_clock > key_time[g]) begin
        if (cur_mode != MODE_BEZIER) cur_frame = f + 1;
        else if (anim_clock > key_time[n - 1]) restart_or_finish();
      end
      case (cur_mode)
        MODE_CONST: begin
          hold_frame(f);
          return 1'b1;
        end
        MODE_LINEAR: begin
          // The tick that steps onto the last frame leaves the values alone.
          if (cur_frame + 1 >= n) return 1'b0;
          lerp_frames(f, g);
          return 1'b1;
        end
        MODE_BEZIER: begin
          casteljau(n);
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    end
    restart_or_finish();
    return 1'b0;
  endfunction

  // Applies one accepted transaction to the shadow state; ticks queue a frame.
  function automatic void predict_frame(in_t it);
    logic [NumValues*32-1:0] vals;
    bit applied;
    case (it.kind)
      KIND_LOAD: begin
        if (it.attribute != AttrBad) begin
          key_time[it.frame_index] = it.frame_time;
          key_val[it.frame_index * NumValues + it.attribute * 3 + 0] = it.vec_x;
          key_val[it.frame_index * NumValues + it.attribute * 3 + 1] = it.vec_y;
          key_val[it.frame_index * NumValues + it.attribute * 3 + 2] = it.vec_z;
        end
      end
      KIND_CLEAR: anim_done = 1'b0;
      KIND_TICK: begin
        applied = advance_tick(it.elapsed);
        for (int i = 0; i < NumValues; i++)
          vals[(NumValues - 1 - i) * 32 +: 32] = held_val[i][31:0];
        frame_q.push_back({vals, applied, anim_done});
      end
      default: ;
    endcase
  endfunction

  // Sends one transaction in bursts separated by random gaps.
  task automatic send(in_t it);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame(it);
    items_sent++;
  endtask

  function automatic in_t noise_fields();
    in_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return it;
  endfunction

  task automatic tick(logic [31:0] elapsed);
    in_t it;
    it = noise_fields();
    it.kind = KIND_TICK;
    it.elapsed = elapsed;
    send(it);
  endtask

  task automatic load(logic [3:0] slot, logic [1:0] attr, logic [31:0] ftime,
                      logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_t it;
    it = noise_fields();
    it.kind = KIND_LOAD;
    it.frame_index = slot;
    it.attribute = attr;
    it.frame_time = ftime;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    send(it);
  endtask

  task automatic clear_done();
    in_t it;
    it = noise_fields();
    it.kind = KIND_CLEAR;
    send(it);
  endtask

  // Waits until every expected frame has arrived and any load in flight is done.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [4:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_MODE:        cur_mode = mode_e'(val[1:0]);
      CFG_REPEAT:      repeat_on = val[0];
      CFG_UPD_POS:     upd_en[0] = val[0];
      CFG_UPD_ANG:     upd_en[1] = val[0];
      CFG_UPD_SCL:     upd_en[2] = val[0];
      CFG_FRAME_COUNT: frame_cnt = val;
      default: ;
    endcase
  endtask

  task automatic configure(mode_e m, bit rep, bit p, bit a, bit s, logic [4:0] n);
    drain();
    write_reg(CFG_MODE, 5'(m));
    write_reg(CFG_REPEAT, 5'(rep));
    write_reg(CFG_UPD_POS, 5'(p));
    write_reg(CFG_UPD_ANG, 5'(a));
    write_reg(CFG_UPD_SCL, 5'(s));
    write_reg(CFG_FRAME_COUNT, n);
  endtask

  // Well-formed key set: rising times from a nonzero start, full-range vectors.
  task automatic load_key_set(int n, int step);
    logic [31:0] base;
    base = $urandom_range(1, 2000);
    for (int k = 0; k < n; k++)
      for (int a = 0; a < 3; a++)
        load(4'(k), 2'(a), base + k * step + $urandom_range(0, step / 4),
             $urandom, $urandom, $urandom);
  endtask

  // Fill every slot so the block never reads an unwritten key.
  task automatic test_fill_keys();
    for (int k = 0; k < MaxFrames; k++) begin
      load(4'(k), AttrPos, 32'd1000 + k * 2000, 32'h7FFF_FFFF, 32'h8000_0000, k << 16);
      load(4'(k), AttrAng, 32'd1000 + k * 2000, 32'h8000_0000, 32'h7FFF_FFFF, -(k << 16));
      load(4'(k), AttrScl, 32'd1000 + k * 2000, k << 14, $urandom, 32'h0);
    end
  endtask

  // Constant mode: a tick before the first key, then steps across all keys to the end.
  task automatic test_constant();
    configure(MODE_CONST, 1'b0, 1'b1, 1'b1, 1'b1, 5'd4);
    tick(32'd400);
    tick(32'd1000);
    tick(32'd2500);
    tick(32'd3000);
    tick(32'd3000);
    tick(32'd0);
    tick(32'd100);
    clear_done();
    tick(32'd100);
  endtask

  // Linear mode with repeat: extrapolation past a key and restart at the end.
  task automatic test_linear();
    configure(MODE_LINEAR, 1'b1, 1'b1, 1'b0, 1'b1, 5'd3);
    load(4'd1, AttrPos, 32'd1000, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF);
    load(4'd1, AttrScl, 32'd1000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    for (int i = 0; i < 6; i++) tick(32'd700);
  endtask

  // Bezier over the largest and smallest key counts, with a zero span.
  task automatic test_bezier();
    configure(MODE_BEZIER, 1'b0, 1'b1, 1'b1, 1'b0, 5'd16);
    tick(32'd5000);
    tick(32'd40000);
    configure(MODE_BEZIER, 1'b1, 1'b0, 1'b1, 1'b1, 5'd0);
    tick(32'd10);
    configure(MODE_BEZIER, 1'b1, 1'b1, 1'b1, 1'b1, 5'd2);
    load(4'd0, AttrAng, 32'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
    tick(32'd50);
  endtask

  // Hold mode, clock saturation, ignored kinds and bad loads, oversized key count.
  task automatic test_odd_cases();
    in_t it;
    configure(MODE_HOLD, 1'b0, 1'b1, 1'b1, 1'b1, 5'd31);
    tick(32'd10);
    it = noise_fields();
    it.kind = KindUnused;
    send(it);
    load(4'd15, AttrBad, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    configure(MODE_CONST, 1'b0, 1'b1, 1'b1, 1'b1, 5'd17);
    tick(32'hFFFF_FFFF);
    tick(32'hFFFF_FFFF);
    clear_done();
  endtask

  // Random phases: a fresh key set and setting, then ticks mixed with noise.
  task automatic test_random();
    int n, step, roll;
    mode_e m;
    in_t it;
    items_sent = 0;
    while (items_sent < RandomItems) begin
      m = mode_e'($urandom_range(0, 3));
      roll = $urandom_range(0, 9);
      if (m == MODE_BEZIER) n = $urandom_range(1, 6);
      else if (roll == 0) n = 0;
      else if (roll == 1) n = $urandom_range(16, 31);
      else n = $urandom_range(1, 8);
      configure(m, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 1), 5'(n));
      step = $urandom_range(256, 6000);
      load_key_set((n == 0) ? 1 : ((n > MaxFrames) ? MaxFrames : n), step);
      clear_done();
      repeat ($urandom_range(5, 25)) begin
        roll = $urandom_range(0, 19);
        if (roll < 14) tick($urandom_range(0, step));
        else if (roll == 14) tick($urandom);
        else if (roll == 15) clear_done();
        else if (roll == 16) begin
          it = noise_fields();
          it.kind = KindUnused;
          send(it);
        end else if (roll == 17) begin
          load($urandom, AttrBad, $urandom, $urandom, $urandom, $urandom);
        end else begin
          load($urandom, $urandom_range(0, 2), $urandom, $urandom, $urandom, $urandom);
        end
      end
      // Now and then let the output side empty completely before going on.
      if ($urandom_range(0, 3) == 0) drain();
    end
  endtask

  // Receiver: stall probability is redrawn whenever stall_age wraps, zero in some stretches.
  int stall_pct = 0;
  int stall_age = 0;
  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 15;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_age = (stall_age + 1) % 64;
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each accepted result frame against the oldest prediction.
  string val_name[NumValues] = '{"pos_x", "pos_y", "pos_z", "ang_x", "ang_y", "ang_z",
                                 "scl_x", "scl_y", "scl_z"};
  always @(posedge clk_i) begin
    out_t want;
    logic [31:0] w, g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result frame at %0t", $realtime);
      end else begin
        want = frame_q.pop_front();
        for (int i = 0; i < NumValues + 2; i++) begin
          if (i < NumValues) begin
            w = want[2 + (NumValues - 1 - i) * 32 +: 32];
            g = out_data_o[2 + (NumValues - 1 - i) * 32 +: 32];
          end else begin
            w = want[NumValues + 1 - i];
            g = out_data_o[NumValues + 1 - i];
          end
          if (w !== g) begin
            errors++;
            if (errors <= 10)
              $display("mismatch %s at %0t: expected %h, got %h",
                       (i < NumValues) ? val_name[i] : ((i == NumValues) ? "applied" : "finished"),
                       $realtime, w, g);
          end
        end
      end
    end
  end

  initial begin
    anim_clock = '0;
    cur_frame = 0;
    anim_done = 1'b0;
    cur_mode = MODE_CONST;
    repeat_on = 1'b0;
    upd_en = '{1'b1, 1'b1, 1'b1};
    frame_cnt = 1;
    for (int i = 0; i < NumValues; i++) held_val[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_keys();
    test_constant();
    test_linear();
    test_bezier();
    test_odd_cases();
    test_random();
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(8 * 6_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
